// ----- hdl/mme_pkg.sv -----
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants for the matrix multiply element
// Item formats, action codes and the structs that travel to the cells.
// ----------------------------------------------------------------------------
package mme_pkg;

	localparam int MAX_WIDTH_DEF = 16;
	localparam int IDX_W         = 4;
	localparam int ELEM_W        = 16;
	localparam int PROD_W        = 2 * ELEM_W;
	localparam int DOT_W         = 36;
	localparam int SIZE_W        = 5;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

	typedef enum logic [1:0] {
		ACT_LOAD_A  = 2'd0,
		ACT_LOAD_B  = 2'd1,
		ACT_COMPUTE = 2'd2
	} action_t;

	typedef struct packed {
		action_t                   action;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic signed [ELEM_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]          out_row;
		logic [IDX_W-1:0]          out_col;
		logic signed [DOT_W-1:0]   dot_value;
	} rsp_t;

	// element write, broadcast to every cell
	typedef struct packed {
		logic                      we_a;
		logic                      we_b;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic signed [ELEM_W-1:0]  data;
	} mme_wr_t;

	// operand read for a compute, broadcast to every cell
	typedef struct packed {
		logic                      en;
		logic                      in_range;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
	} mme_rd_t;

endpackage

// ----- hdl/matrix_multiply_element.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_element: one element of a square matrix product
// Stores matrices A and B and returns single elements of A*B on request.
// ----------------------------------------------------------------------------
// Load transfers write one Q8.8 element of A or B; they give no result. A
// compute transfer returns element (row, col) of A*B as an exact Q20.16 sum
// over the first matrix_size terms, at most MAX_WIDTH. Storage is split over
// a chain of MAX_WIDTH cells: cell k holds column k of A and row k of B, so
// all cells read their operands and multiply at once, and the partial sum
// then walks the chain one cell per cycle unless a held result stalls it. A
// compute passes from its transfer to a valid result through the operand
// read at the transfer edge, one multiply, MAX_WIDTH chain adds and the
// result register; the next item is taken the cycle after the sum leaves
// the chain. The finished result waits in its own register, so the next
// item is accepted while the result is still held by a stalled consumer.
// Loads with row or col at or beyond MAX_WIDTH are dropped; computes there
// return zero. Write matrix_size only while no compute is in flight.
// ----------------------------------------------------------------------------
module matrix_multiply_element #(
	parameter int MAX_WIDTH = mme_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        req_valid,
	output logic                        req_ready,
	input  mme_pkg::req_t               req,
	// result channel
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output mme_pkg::rsp_t               rsp,
	// matrix_size register
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mme_pkg::SIZE_W-1:0]  cfg_data
);

	localparam int DW = mme_pkg::DOT_W;

	logic [mme_pkg::SIZE_W-1:0]  size_q;
	logic                        busy_q;
	logic                        launch_s1;
	logic                        launch_s2;
	logic [mme_pkg::IDX_W-1:0]   row_q;
	logic [mme_pkg::IDX_W-1:0]   col_q;
	logic                        rsp_valid_q;
	mme_pkg::rsp_t               rsp_q;

	logic                        req_xfer;
	logic                        in_range;
	logic                        is_compute;
	logic                        advance;
	logic                        done;
	mme_pkg::mme_wr_t            wr;
	mme_pkg::mme_rd_t            rd;

	logic signed [DW-1:0]        sum_chain   [MAX_WIDTH+1];
	logic                        valid_chain [MAX_WIDTH+1];

	// one compute in flight at a time; loads wait behind it too
	assign req_ready  = !busy_q;
	assign req_xfer   = req_valid && req_ready;
	assign cfg_ready  = 1'b1;
	assign in_range   = (int'(req.row) < MAX_WIDTH) && (int'(req.col) < MAX_WIDTH);
	assign is_compute = (req.action == mme_pkg::ACT_COMPUTE);

	always_comb begin
		wr.we_a     = 1'b0;
		wr.we_b     = 1'b0;
		wr.row      = req.row;
		wr.col      = req.col;
		wr.data     = req.value;
		rd.en       = 1'b0;
		rd.in_range = in_range;
		rd.row      = req.row;
		rd.col      = req.col;
		case (req.action)
			mme_pkg::ACT_LOAD_A:  wr.we_a = req_xfer && in_range;
			mme_pkg::ACT_LOAD_B:  wr.we_b = req_xfer && in_range;
			mme_pkg::ACT_COMPUTE: rd.en   = req_xfer;
			default: ;  // unused action: no effect
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= mme_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	// the sum leaves the last cell when the result register is free
	assign done    = valid_chain[MAX_WIDTH] && advance;
	assign advance = !(valid_chain[MAX_WIDTH] && rsp_valid_q && !rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			launch_s1 <= 1'b0;
			launch_s2 <= 1'b0;
		end else begin
			launch_s1 <= req_xfer && is_compute;
			launch_s2 <= launch_s1;
			if (req_xfer && is_compute) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer && is_compute) begin
			row_q <= req.row;
			col_q <= req.col;
		end
	end

	// partial sum enters cell 0 once the products are registered
	assign sum_chain[0]   = '0;
	assign valid_chain[0] = launch_s2;

	for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
		mme_cell #(
			.MAX_WIDTH (MAX_WIDTH),
			.CELL_IDX  (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr        (wr),
			.rd        (rd),
			.size      (size_q),
			.advance   (advance),
			.sum_in    (sum_chain[k]),
			.valid_in  (valid_chain[k]),
			.sum_out   (sum_chain[k+1]),
			.valid_out (valid_chain[k+1])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q.out_row   <= row_q;
			rsp_q.out_col   <= col_q;
			rsp_q.dot_value <= sum_chain[MAX_WIDTH];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hdl/mme_cell.sv -----
// ----------------------------------------------------------------------------
// mme_cell: one term of the dot product
// Holds column CELL_IDX of A and row CELL_IDX of B, forms its product and
// adds it to the partial sum passing down the chain.
// ----------------------------------------------------------------------------
module mme_cell #(
	parameter int MAX_WIDTH = mme_pkg::MAX_WIDTH_DEF,
	parameter int CELL_IDX  = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mme_pkg::mme_wr_t                  wr,
	input  mme_pkg::mme_rd_t                  rd,
	input  logic [mme_pkg::SIZE_W-1:0]        size,
	input  logic                              advance,
	input  logic signed [mme_pkg::DOT_W-1:0]  sum_in,
	input  logic                              valid_in,
	output logic signed [mme_pkg::DOT_W-1:0]  sum_out,
	output logic                              valid_out
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int PW = mme_pkg::PROD_W;
	localparam int DW = mme_pkg::DOT_W;

	logic signed [mme_pkg::ELEM_W-1:0] mem_a [MAX_WIDTH];  // A[*][CELL_IDX]
	logic signed [mme_pkg::ELEM_W-1:0] mem_b [MAX_WIDTH];  // B[CELL_IDX][*]

	logic signed [mme_pkg::ELEM_W-1:0] a_rd_q;
	logic signed [mme_pkg::ELEM_W-1:0] b_rd_q;
	logic                              use_q;
	logic signed [PW-1:0]              product_q;
	logic signed [DW-1:0]              sum_q;
	logic                              valid_q;

	logic sel_a;
	logic sel_b;

	assign sel_a = wr.we_a && (int'(wr.col) == CELL_IDX);
	assign sel_b = wr.we_b && (int'(wr.row) == CELL_IDX);

	always_ff @(posedge clk) begin
		if (sel_a) begin
			mem_a[AW'(wr.row)] <= wr.data;
		end
		if (sel_b) begin
			mem_b[AW'(wr.col)] <= wr.data;
		end
		if (rd.en) begin
			a_rd_q <= mem_a[AW'(rd.row)];
			b_rd_q <= mem_b[AW'(rd.col)];
		end
	end

	// term enable: index in range and this term below matrix_size
	always_ff @(posedge clk) begin
		if (rd.en) begin
			use_q <= rd.in_range && (CELL_IDX < int'(size));
		end
	end

	always_ff @(posedge clk) begin
		if (use_q) begin
			product_q <= a_rd_q * b_rd_q;
		end else begin
			product_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sum_q <= sum_in + {{(DW-PW){product_q[PW-1]}}, product_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_in;
		end
	end

	assign sum_out   = sum_q;
	assign valid_out = valid_q;

endmodule

// ----- hdl/mme_checker.sv -----
// ----------------------------------------------------------------------------
// mme_checker: port-level checks for matrix_multiply_element
// Watches the request, result and register ports over time.
// ----------------------------------------------------------------------------
module mme_checker #(
	parameter int MAX_WIDTH = mme_pkg::MAX_WIDTH_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input mme_pkg::req_t               req,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input mme_pkg::rsp_t               rsp,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic [mme_pkg::SIZE_W-1:0]  cfg_data
);

	logic req_xfer;
	logic cfg_xfer;

	assign req_xfer = req_valid && req_ready;
	assign cfg_xfer = cfg_valid && cfg_ready && (cfg_data == cfg_data);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// a compute, once taken, blocks the request side
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer && (req.action == mme_pkg::ACT_COMPUTE) |=> !req_ready)
		else $error("request taken during a compute");

	// loads and unused actions never make a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer && (req.action != mme_pkg::ACT_COMPUTE) && !rsp_valid
		|=> !rsp_valid)
		else $error("result without a compute");

	// a new result only appears at the end of a compute
	a_rsp_from_compute: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared while idle");

	// out-of-range indices give a zero sum
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !cfg_xfer
		&& ((int'(rsp.out_row) >= MAX_WIDTH) || (int'(rsp.out_col) >= MAX_WIDTH))
		|-> rsp.dot_value == '0)
		else $error("nonzero sum outside the matrix");

endmodule

bind matrix_multiply_element mme_checker #(.MAX_WIDTH(MAX_WIDTH)) u_mme_checker (.*);

// ----- verif/matrix_multiply_element_test.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_element_test: self-checking bench for the product element
// Loads A and B over the request channel, asks for product elements, and
// compares every result against an exact fixed-point dot product kept here.
// ----------------------------------------------------------------------------
module matrix_multiply_element_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mme_pkg::*;

	localparam int MAX_W        = MAX_WIDTH_DEF;
	localparam int RESET_CYCLES = 12;
	// margin for a compute to finish before touching matrix_size
	localparam int SETTLE       = MAX_W + 10;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 1530;
	localparam int N_PHASES     = 11;
	localparam int MAX_REPORTS  = 10;
	// the one action code the package leaves unnamed
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	req_t                req       = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	rsp_t                rsp;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [SIZE_W-1:0]   cfg_data  = '0;

	matrix_multiply_element #(
		.MAX_WIDTH(MAX_W)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the block: both matrices, which entries hold data,
	// and the size register. Updated at the edge a transfer happens.
	// ------------------------------------------------------------------
	logic signed [ELEM_W-1:0] mat_a [MAX_W][MAX_W];
	logic signed [ELEM_W-1:0] mat_b [MAX_W][MAX_W];
	bit                       a_written [MAX_W][MAX_W];
	bit                       b_written [MAX_W][MAX_W];
	logic [SIZE_W-1:0]        mat_size = SIZE_RESET;

	// product elements still owed by the block, oldest first
	rsp_t pending_products [$];

	int  errors     = 0;
	int  n_loads    = 0;
	int  n_computes = 0;
	int  n_ignored  = 0;
	int  n_checked  = 0;
	int  n_sizes    = 0;
	int  cycles     = 0;
	// when set, neither side inserts idle cycles
	bit  calm       = 1'b0;

	// Exact Q20.16 sum of row r of A times column c of B. The term count is
	// the size register clamped to the array width; zero gives zero.
	function automatic logic signed [DOT_W-1:0] product_element(
		input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c
	);
		longint acc;
		int     terms;
		acc   = 0;
		terms = (mat_size > MAX_W) ? MAX_W : mat_size;
		for (int k = 0; k < terms; k++)
			acc += longint'(mat_a[r][k]) * longint'(mat_b[k][c]);
		return acc[DOT_W-1:0];
	endfunction

	// Element values lean on the corners of Q8.8 now and then.
	function automatic logic [ELEM_W-1:0] pick_element();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	// Book-keeping for an accepted request. A compute owes one result: the
	// typed value when the caller supplies one, otherwise the prediction.
	task automatic record_request(
		input req_t                    item,
		input bit                      typed,
		input logic signed [DOT_W-1:0] dot
	);
		logic signed [DOT_W-1:0] owed;
		case (item.action)
			ACT_LOAD_A: begin
				mat_a[item.row][item.col]     = item.value;
				a_written[item.row][item.col] = 1'b1;
				n_loads++;
			end
			ACT_LOAD_B: begin
				mat_b[item.row][item.col]     = item.value;
				b_written[item.row][item.col] = 1'b1;
				n_loads++;
			end
			ACT_COMPUTE: begin
				owed = typed ? dot : product_element(item.row, item.col);
				pending_products.push_back(rsp_t'{out_row: item.row, out_col: item.col,
					dot_value: owed});
				n_computes++;
			end
			default: begin
				// unused action: no state change, no result
				n_ignored++;
			end
		endcase
	endtask

	// One request transfer. A random gap may come first; valid then stays
	// high with a fixed payload until the transfer. Valid is left high so
	// back-to-back items need no extra assignment.
	task automatic send_request(
		input req_t                    item,
		input bit                      typed,
		input logic signed [DOT_W-1:0] dot
	);
		logic [$bits(req_t)-1:0] junk;
		if (!calm && $urandom_range(99) < 35) begin
			junk = $bits(req_t)'($urandom);
			req_valid <= 1'b0;
			req       <= junk;
			do @(posedge clk); while (!calm && $urandom_range(99) < 35);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		record_request(item, typed, dot);
	endtask

	// Stop sending, let every owed result drain, then give the pipeline
	// time to empty of loads before the size register is touched.
	task automatic drain_and_settle();
		req_valid <= 1'b0;
		while (pending_products.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Size register write; only ever called with the block idle.
	task automatic write_size(input logic [SIZE_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mat_size = v;
		n_sizes++;
	endtask

	// ------------------------------------------------------------------
	// Directed script: size writes and items, some with the result typed in
	// ------------------------------------------------------------------
	typedef struct {
		bit                      is_cfg;
		logic [SIZE_W-1:0]       size;
		req_t                    item;
		bit                      typed;
		logic signed [DOT_W-1:0] dot;
	} script_row_t;

	script_row_t script [$];

	task automatic script_size(input logic [SIZE_W-1:0] v);
		script_row_t s;
		s        = '{default: '0};
		s.is_cfg = 1'b1;
		s.size   = v;
		script.push_back(s);
	endtask

	task automatic script_item(
		input logic [1:0]              act,
		input logic [IDX_W-1:0]        r,
		input logic [IDX_W-1:0]        c,
		input logic [ELEM_W-1:0]       v,
		input bit                      typed,
		input logic signed [DOT_W-1:0] dot
	);
		script_row_t s;
		s             = '{default: '0};
		s.item.action = action_t'(act);
		s.item.row    = r;
		s.item.col    = c;
		s.item.value  = v;
		s.typed       = typed;
		s.dot         = dot;
		script.push_back(s);
	endtask

	// ------------------------------------------------------------------
	// Random requests. A compute picks a target element and sticks with it;
	// while an operand it needs has never been written, the slot turns into
	// a load of that operand, so computes never touch empty entries and the
	// stream is mostly fill-then-compute runs mixed with stray loads and
	// unused actions.
	// ------------------------------------------------------------------
	bit               target_set = 1'b0;
	logic [IDX_W-1:0] tgt_row;
	logic [IDX_W-1:0] tgt_col;

	task automatic random_request(output req_t item);
		int pick;
		int terms;
		bit missing;
		item.row   = IDX_W'($urandom);
		item.col   = IDX_W'($urandom);
		item.value = pick_element();
		pick       = $urandom_range(99);
		if (pick < 5) begin
			item.action = action_t'(ACT_UNUSED);
		end else if (pick < 30) begin
			item.action = ACT_LOAD_A;
		end else if (pick < 55) begin
			item.action = ACT_LOAD_B;
		end else begin
			if (!target_set) begin
				tgt_row    = IDX_W'($urandom);
				tgt_col    = IDX_W'($urandom);
				target_set = 1'b1;
			end
			item.action = ACT_COMPUTE;
			item.row    = tgt_row;
			item.col    = tgt_col;
			terms       = (mat_size > MAX_W) ? MAX_W : mat_size;
			missing     = 1'b0;
			for (int k = 0; k < terms; k++) begin
				if (!missing && !a_written[tgt_row][k]) begin
					item.action = ACT_LOAD_A;
					item.row    = tgt_row;
					item.col    = IDX_W'(k);
					missing     = 1'b1;
				end else if (!missing && !b_written[k][tgt_col]) begin
					item.action = ACT_LOAD_B;
					item.row    = IDX_W'(k);
					item.col    = tgt_col;
					missing     = 1'b1;
				end
			end
			if (!missing)
				target_set = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random back-pressure, then check each transfer against
	// the oldest owed product element.
	// ------------------------------------------------------------------
	always @(posedge clk)
		rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 35);

	task automatic flag_mismatch(input string what, input rsp_t want, input rsp_t got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("[%0t] %s: expected row %0d col %0d dot %0d, got row %0d col %0d dot %0d",
				$realtime, what, want.out_row, want.out_col, want.dot_value,
				got.out_row, got.out_col, got.dot_value);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_products.size() == 0) begin
				flag_mismatch("result with nothing owed", '0, rsp);
			end else begin
				want = pending_products.pop_front();
				n_checked++;
				if (rsp.out_row !== want.out_row)
					flag_mismatch("out_row", want, rsp);
				else if (rsp.out_col !== want.out_col)
					flag_mismatch("out_col", want, rsp);
				else if (rsp.dot_value !== want.dot_value)
					flag_mismatch("dot_value", want, rsp);
			end
		end
	end

	// Watchdog: counts cycles and ends a hung run.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding",
			cycles, pending_products.size());
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	int size_plan [N_PHASES] = '{16, 1, 31, 0, 2, 17, 7, 16, 12, 5, 3};

	initial begin
		req_t item;
		int   per_phase;
		int   taken;
		int   n_rand;

		// Directed part. With a single term a product is one Q8.8 times
		// Q8.8, so the corners can be written out by hand.
		script_item(ACT_UNUSED, 4'd15, 4'd15, 16'h7FFF, 1'b0, '0); // dropped
		script_size(5'd1);
		script_item(ACT_LOAD_A, 4'd0, 4'd0, 16'h7FFF, 1'b0, '0);
		script_item(ACT_LOAD_B, 4'd0, 4'd0, 16'h7FFF, 1'b0, '0);
		script_item(ACT_COMPUTE, 4'd0, 4'd0, 16'h0000, 1'b1, 36'sd1073676289);
		script_item(ACT_LOAD_A, 4'd15, 4'd0, 16'h8000, 1'b0, '0);
		script_item(ACT_LOAD_B, 4'd0, 4'd15, 16'h8000, 1'b0, '0);
		// most negative squared, then both mixed-sign corners
		script_item(ACT_COMPUTE, 4'd15, 4'd15, 16'h0000, 1'b1, 36'sd1073741824);
		script_item(ACT_COMPUTE, 4'd0, 4'd15, 16'h0000, 1'b1, -36'sd1073709056);
		script_item(ACT_COMPUTE, 4'd15, 4'd0, 16'h0000, 1'b1, -36'sd1073709056);
		// unused action must leave A(0,0) alone
		script_item(ACT_UNUSED, 4'd0, 4'd0, 16'h0000, 1'b0, '0);
		script_item(ACT_COMPUTE, 4'd0, 4'd0, 16'hFFFF, 1'b1, 36'sd1073676289);
		// 1.0 times 1.0 is 1.0 in Q20.16
		script_item(ACT_LOAD_A, 4'd0, 4'd0, 16'h0100, 1'b0, '0);
		script_item(ACT_LOAD_B, 4'd0, 4'd0, 16'h0100, 1'b0, '0);
		script_item(ACT_COMPUTE, 4'd0, 4'd0, 16'h0000, 1'b1, 36'sd65536);
		// zero terms: always zero
		script_size(5'd0);
		script_item(ACT_COMPUTE, 4'd15, 4'd15, 16'h7FFF, 1'b1, 36'sd0);
		// two terms: 1.0*1.0 + (-1/256)*(-128)
		script_size(5'd2);
		script_item(ACT_LOAD_A, 4'd0, 4'd1, 16'hFFFF, 1'b0, '0);
		script_item(ACT_LOAD_B, 4'd1, 4'd0, 16'h8000, 1'b0, '0);
		script_item(ACT_COMPUTE, 4'd0, 4'd0, 16'h8000, 1'b1, 36'sd98304);
		// row beyond the size still sums the stored elements
		script_item(ACT_LOAD_A, 4'd15, 4'd1, 16'h7FFF, 1'b0, '0);
		script_item(ACT_COMPUTE, 4'd15, 4'd0, 16'h0000, 1'b0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				drain_and_settle();
				write_size(script[i].size);
			end else begin
				send_request(script[i].item, script[i].typed, script[i].dot);
			end
		end

		// Random part: one size per phase, drained between phases. The
		// sender's drain before each write doubles as the pause that lets
		// every owed result come home with nothing new in flight.
		per_phase = RANDOM_ITEMS / N_PHASES;
		n_rand    = 0;
		foreach (size_plan[p]) begin
			drain_and_settle();
			write_size(SIZE_W'(size_plan[p]));
			taken = 0;
			while (taken < per_phase) begin
				// a long stretch with both sides running flat out
				calm = (n_rand >= 700 && n_rand < 900);
				random_request(item);
				send_request(item, 1'b0, '0);
				if (item.action != action_t'(ACT_UNUSED)) begin
					taken++;
					n_rand++;
				end
			end
			calm = 1'b0;
		end

		drain_and_settle();
		repeat (2 * SETTLE) @(posedge clk);
		errors += pending_products.size();

		$display("Covered %0d loads, %0d computes, %0d unused-action items, %0d results checked",
			n_loads, n_computes, n_ignored, n_checked);
		$display("Size register written %0d times, 0 through 31, over %0d cycles",
			n_sizes, cycles);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/mme_pkg.sv
hdl/mme_cell.sv
hdl/matrix_multiply_element.sv
hdl/mme_checker.sv
verif/matrix_multiply_element_test.sv
